### rtl/i2dc_pkg.sv
// Shared types and constants of the 2-D convolution block.
// No dependencies; every other file but i2dc_ram depends on this package.
package i2dc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COL_W + 1;
  localparam int ROW_W     = 16;
  localparam int ROWS      = 5;
  localparam int SLOT_W    = 3;
  localparam int GRID      = 5;
  localparam int TAPS      = GRID * GRID;
  localparam int PIXEL_BITS = 16;
  localparam int COEF_BITS = 8;
  localparam int PROD_W    = PIXEL_BITS + COEF_BITS;
  localparam int CNT_W     = 12;
  localparam int CFG_W     = 64;
  localparam int IDX_W     = 3;
  localparam int WIN_COLS  = 4;
  localparam int HEAD_COLS = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic [COL_W-1:0]             col_t;
  typedef logic [SLOT_W-1:0]            slot_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH, REG_HEIGHT, REG_RADIUS_X, REG_RADIUS_Y,
    REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3
  } cfg_reg_t;

  typedef struct packed {
    logic                  border;
    logic                  last;
    pixel_t                center;
    pixel_t [TAPS-1:0]     tap;
    coef_t  [TAPS-1:0]     coef;
  } taps_t;

endpackage

### rtl/i2dc_in_if.sv
// Input stream channel: valid/ready handshake with op and pixel payload.
// Depends on i2dc_pkg for the pixel type.
interface i2dc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  i2dc_pkg::pixel_t   pixel_in;
  modport source(output valid, op, pixel_in, input ready);
  modport sink(input valid, op, pixel_in, output ready);
endinterface

### rtl/i2dc_out_if.sv
// Result stream channel: valid/ready handshake with pixel and frame marker.
// Depends on i2dc_pkg for the pixel type.
interface i2dc_out_if;
  logic               valid;
  logic               ready;
  i2dc_pkg::pixel_t   pixel_out;
  logic               frame_last;
  modport source(output valid, pixel_out, frame_last, input ready);
  modport sink(input valid, pixel_out, frame_last, output ready);
endinterface

### rtl/i2dc_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// Standalone; no package needed.
module i2dc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/i2dc_front.sv
// Configuration registers, line store, positions and the coherent 5x5 window.
// Depends on i2dc_pkg and i2dc_ram.
module i2dc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [i2dc_pkg::IDX_W-1:0] cfg_index,
  input  logic [i2dc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_op,
  input  i2dc_pkg::pixel_t           in_pixel,
  input  logic                       take,
  output logic                       emit_valid,
  output i2dc_pkg::taps_t            taps
);
  import i2dc_pkg::*;

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [1:0]         rx_r, ry_r;
  coef_t              coef_r [TAPS];

  logic [WIDTH_W-1:0] w;
  logic [ROW_W-1:0]   h;
  logic [1:0]         rx, ry;
  logic [CNT_W-1:0]   lag;

  col_t               in_col, out_col;
  logic [ROW_W-1:0]   in_row, out_row;
  slot_t              in_slot, out_slot;
  logic [CNT_W-1:0]   pending;

  pixel_t             win  [WIN_COLS][ROWS];
  pixel_t             head [HEAD_COLS][ROWS];
  pixel_t             weff [WIN_COLS+1][ROWS];
  pixel_t             heff [HEAD_COLS][ROWS];
  pixel_t             rdata [ROWS];

  logic               wr_prev_valid;
  slot_t              wr_prev_slot;
  col_t               wr_prev_col;
  pixel_t             wr_prev_data;
  col_t               rd_addr, rd_addr_q;

  logic               fire, wr, emit, in_wrap, out_wrap;
  col_t               ox_next;

  // effective geometry
  always_comb begin
    if (width_r == '0) w = WIDTH_W'(1);
    else if (width_r > WIDTH_W'(MAX_WIDTH)) w = WIDTH_W'(MAX_WIDTH);
    else w = width_r;
    h  = (height_r == '0) ? ROW_W'(1) : height_r;
    rx = (rx_r == 2'd3) ? 2'd2 : rx_r;
    ry = (ry_r == 2'd3) ? 2'd2 : ry_r;
    unique case (ry)
      2'd0:    lag = CNT_W'(rx);
      2'd1:    lag = CNT_W'(w) + CNT_W'(rx);
      default: lag = (CNT_W'(w) << 1) + CNT_W'(rx);
    endcase
  end

  assign fire     = in_valid && take;
  assign wr       = fire && (in_op == OP_PIXEL);
  assign emit     = fire && ((in_op == OP_DRAIN) ? (pending != '0)
                                                 : ((pending + CNT_W'(1)) > lag));
  assign in_wrap  = ({1'b0, in_col} + WIDTH_W'(1)) >= w;
  assign out_wrap = ({1'b0, out_col} + WIDTH_W'(1)) >= w;
  assign ox_next  = emit ? (out_wrap ? '0 : out_col + COL_W'(1)) : out_col;
  assign rd_addr  = rst ? COL_W'(2) : ox_next + COL_W'(2);
  assign emit_valid = emit;

  // line store: one RAM per row slot, all read at the same column
  for (genvar k = 0; k < ROWS; k++) begin : g_store
    i2dc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (wr && (in_slot == SLOT_W'(k))),
      .waddr (in_col),
      .wdata (in_pixel),
      .raddr (rd_addr),
      .rdata (rdata[k])
    );
  end

  // window as the store holds it after this cycle's write
  always_comb begin
    for (int s = 0; s < ROWS; s++) begin
      for (int j = 0; j < WIN_COLS; j++) begin
        weff[j][s] = win[j][s];
        if (wr && in_slot == SLOT_W'(s) && in_col == out_col + COL_W'(j) - COL_W'(2))
          weff[j][s] = in_pixel;
      end
      weff[WIN_COLS][s] = rdata[s];
      if (wr_prev_valid && wr_prev_slot == SLOT_W'(s) && wr_prev_col == rd_addr_q)
        weff[WIN_COLS][s] = wr_prev_data;
      if (wr && in_slot == SLOT_W'(s) && in_col == rd_addr_q)
        weff[WIN_COLS][s] = in_pixel;
      for (int c = 0; c < HEAD_COLS; c++) begin
        heff[c][s] = head[c][s];
        if (wr && in_slot == SLOT_W'(s) && in_col == COL_W'(c))
          heff[c][s] = in_pixel;
      end
    end
  end

  // gather taps for the output position
  always_comb begin
    logic [3:0] sl;
    int         k;
    for (int dy = 0; dy < GRID; dy++) begin
      sl = 4'(out_slot) + 4'(dy) + 4'd3;
      if (sl >= 4'd10) sl = sl - 4'd10;
      else if (sl >= 4'd5) sl = sl - 4'd5;
      for (int dx = 0; dx < GRID; dx++) begin
        k = dy * GRID + dx;
        // zero taps outside the kernel so stale store words never reach the sum
        if ((dy + int'(ry) >= 2) && (dy <= 2 + int'(ry)) &&
            (dx + int'(rx) >= 2) && (dx <= 2 + int'(rx))) begin
          taps.tap[k]  = weff[dx][sl[SLOT_W-1:0]];
          taps.coef[k] = coef_r[k];
        end else begin
          taps.tap[k]  = '0;
          taps.coef[k] = '0;
        end
      end
    end
    taps.center = weff[2][out_slot];
    taps.border = ({1'b0, out_col} < WIDTH_W'(rx)) ||
                  (({1'b0, out_col} + WIDTH_W'(rx)) >= w) ||
                  (out_row < ROW_W'(ry)) ||
                  (({1'b0, out_row} + (ROW_W+1)'(ry)) >= {1'b0, h});
    taps.last   = out_wrap && (({1'b0, out_row} + (ROW_W+1)'(1)) >= {1'b0, h});
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WIDTH_W'(MAX_WIDTH);
      height_r <= ROW_W'(1024);
      rx_r     <= 2'd1;
      ry_r     <= 2'd1;
      for (int k = 0; k < TAPS; k++) coef_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:   height_r <= cfg_data[ROW_W-1:0];
        REG_RADIUS_X: rx_r     <= cfg_data[1:0];
        REG_RADIUS_Y: ry_r     <= cfg_data[1:0];
        REG_COEF0:    for (int k = 0; k < 8; k++) coef_r[k]      <= cfg_data[8*k +: 8];
        REG_COEF1:    for (int k = 0; k < 8; k++) coef_r[8 + k]  <= cfg_data[8*k +: 8];
        REG_COEF2:    for (int k = 0; k < 8; k++) coef_r[16 + k] <= cfg_data[8*k +: 8];
        REG_COEF3:    coef_r[24] <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // positions, pending count and window tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col        <= '0;
      in_row        <= '0;
      in_slot       <= '0;
      out_col       <= '0;
      out_row       <= '0;
      out_slot      <= '0;
      pending       <= '0;
      wr_prev_valid <= 1'b0;
      for (int s = 0; s < ROWS; s++) begin
        for (int j = 0; j < WIN_COLS; j++) win[j][s] <= '0;
        for (int c = 0; c < HEAD_COLS; c++) head[c][s] <= '0;
      end
    end else begin
      wr_prev_valid <= wr;
      if (fire) begin
        pending <= pending + CNT_W'(wr) - CNT_W'(emit);
      end
      if (wr) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_slot <= (in_slot == SLOT_W'(ROWS-1)) ? '0 : in_slot + SLOT_W'(1);
          in_row  <= (({1'b0, in_row} + (ROW_W+1)'(1)) >= {1'b0, h}) ? '0
                                                                     : in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_wrap) begin
          out_col  <= '0;
          out_slot <= (out_slot == SLOT_W'(ROWS-1)) ? '0 : out_slot + SLOT_W'(1);
          out_row  <= (({1'b0, out_row} + (ROW_W+1)'(1)) >= {1'b0, h}) ? '0
                                                                       : out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
      for (int s = 0; s < ROWS; s++) begin
        for (int c = 0; c < HEAD_COLS; c++) head[c][s] <= heff[c][s];
        if (emit && out_wrap) begin
          // restart at column 0: columns 0 and 1 come from the head copy
          win[0][s] <= weff[0][s];
          win[1][s] <= weff[1][s];
          win[2][s] <= heff[0][s];
          win[3][s] <= heff[1][s];
        end else if (emit) begin
          for (int j = 0; j < WIN_COLS; j++) win[j][s] <= weff[j+1][s];
        end else begin
          for (int j = 0; j < WIN_COLS; j++) win[j][s] <= weff[j][s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_prev_slot <= in_slot;
    wr_prev_col  <= in_col;
    wr_prev_data <= in_pixel;
    rd_addr_q    <= rd_addr;
  end

endmodule

### rtl/i2dc_mac.sv
// Multiply-accumulate pipeline: products, partial sums, output register.
// Depends on i2dc_pkg.
module i2dc_mac (
  input  logic             clk,
  input  logic             rst,
  input  logic             emit_valid,
  input  i2dc_pkg::taps_t  taps,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output i2dc_pkg::pixel_t out_pixel,
  output logic             out_last
);
  import i2dc_pkg::*;

  logic   s1_valid, s2_valid;
  pixel_t prod [TAPS];
  logic   s1_border, s1_last, s2_border, s2_last;
  pixel_t s1_center, s2_center;
  pixel_t part [GRID];
  logic   out_go, s2_go;
  logic signed [PROD_W-1:0] mul [TAPS];
  pixel_t part_next [GRID];
  pixel_t total;

  assign out_go = !out_valid || out_ready;
  assign s2_go  = !s2_valid || out_go;
  assign take   = !s1_valid || s2_go;

  always_comb begin
    for (int k = 0; k < TAPS; k++) mul[k] = taps.tap[k] * taps.coef[k];
    for (int r = 0; r < GRID; r++) begin
      part_next[r] = prod[r*GRID] + prod[r*GRID+1] + prod[r*GRID+2]
                   + prod[r*GRID+3] + prod[r*GRID+4];
    end
    total = part[0] + part[1] + part[2] + part[3] + part[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take)   s1_valid  <= emit_valid;
      if (s2_go)  s2_valid  <= s1_valid;
      if (out_go) out_valid <= s2_valid;
    end
  end

  // payload: wrap every product and sum to the pixel width
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < TAPS; k++) prod[k] <= mul[k][PIXEL_BITS-1:0];
      s1_border <= taps.border;
      s1_last   <= taps.last;
      s1_center <= taps.center;
    end
    if (s2_go) begin
      for (int r = 0; r < GRID; r++) part[r] <= part_next[r];
      s2_border <= s1_border;
      s2_last   <= s1_last;
      s2_center <= s1_center;
    end
    if (out_go) begin
      out_pixel <= s2_border ? s2_center : total;
      out_last  <= s2_last;
    end
  end

endmodule

### rtl/image_2d_convolution.sv
// Top level of the streaming 2-D convolution block.
// Depends on i2dc_pkg, i2dc_in_if, i2dc_out_if, i2dc_front and i2dc_mac.
//
// Use:
//   src carries one beat per item: op selects a pixel (raster order, x fastest)
//   or a drain beat that flushes one pending result. dst carries the results:
//   pixel_out, correlated with the kernel or passed through in the border, and
//   frame_last on the bottom-right pixel of the frame.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user must
//   write it only while idle, which the block does not enforce. A pixel beat
//   yields a result once ry*width+rx pixels are pending; drains flush the rest
//   at the end of a stream. Throughput: one beat per clock unless a dst stall
//   has filled the pipeline. The line store is five column-addressed RAMs
//   read once per cycle; a window of registers shifts one column per result,
//   so every result needs just one new column read. A result passes the
//   product, partial-sum and output registers in turn before it reaches dst.
//   Reset clears positions, pending count and the pipeline; the line store is
//   not cleared, so no clearing pass is needed.
//   When dst stalls, the pipeline stages fill up before src.ready drops.
module image_2d_convolution (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [i2dc_pkg::IDX_W-1:0] cfg_index,
  input  logic [i2dc_pkg::CFG_W-1:0] cfg_data,
  i2dc_in_if.sink                    src,
  i2dc_out_if.source                 dst
);
  import i2dc_pkg::*;

  logic  take, emit_valid;
  taps_t taps;

  assign src.ready = take;

  i2dc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (src.valid),
    .in_op      (src.op),
    .in_pixel   (src.pixel_in),
    .take       (take),
    .emit_valid (emit_valid),
    .taps       (taps)
  );

  i2dc_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .taps       (taps),
    .take       (take),
    .out_valid  (dst.valid),
    .out_ready  (dst.ready),
    .out_pixel  (dst.pixel_out),
    .out_last   (dst.frame_last)
  );

endmodule

### tb/sv/conv_checker.sv
`timescale 1ns / 1ps
// Scoreboard for image_2d_convolution: mirrors the line store and positions,
// predicts each result from the input beats and compares dst beats in order.
// Depends on i2dc_pkg, i2dc_in_if and i2dc_out_if.
module conv_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [i2dc_pkg::IDX_W-1:0] cfg_index,
  input  logic [i2dc_pkg::CFG_W-1:0] cfg_data,
  i2dc_in_if                         src,
  i2dc_out_if                        dst,
  output int                         errors,
  output int                         outstanding,
  output int                         results_seen
);
  import i2dc_pkg::*;

  typedef struct packed {
    pixel_t pix;
    logic   fin;
  } conv_result_t;

  conv_result_t result_q[$];
  pixel_t       line_mem [ROWS][MAX_WIDTH];
  logic [10:0]  cfg_width;
  logic [15:0]  cfg_height;
  logic [1:0]   cfg_rad_x, cfg_rad_y;
  logic [63:0]  coef_word [4];
  int           in_col, in_row, in_slot, out_col, out_row, out_slot, pend;

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic int eff_rad(logic [1:0] r);
    return (r > 2) ? 2 : r;
  endfunction

  function automatic coef_t coef_of(int k);
    return coef_t'(coef_word[k >> 3] >> (8 * (k & 7)));
  endfunction

  task automatic step_pos(inout int col, inout int row, inout int slot, input int w, input int h);
    if (col + 1 >= w) begin
      col = 0;
      slot = (slot + 1) % ROWS;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  task automatic predict_result(int w, int h, int rx, int ry);
    int ox, oy, acc, sl, cl;
    conv_result_t r;
    ox = out_col % MAX_WIDTH;
    oy = out_row;
    if (ox < rx || ox + rx >= w || oy < ry || oy + ry >= h) begin
      r.pix = line_mem[out_slot][ox];
    end else begin
      acc = 0;
      for (int dy = -ry; dy <= ry; dy++) begin
        sl = (out_slot + ROWS + dy) % ROWS;
        for (int dx = -rx; dx <= rx; dx++) begin
          cl = (ox + dx) % MAX_WIDTH;
          acc += int'(line_mem[sl][cl]) * int'(coef_of((dy + 2) * GRID + dx + 2));
        end
      end
      r.pix = pixel_t'(acc);
    end
    r.fin = (out_col + 1 >= w) && (out_row + 1 >= h);
    result_q.push_back(r);
    step_pos(out_col, out_row, out_slot, w, h);
    pend--;
  endtask

  task automatic take_beat(logic op, pixel_t pix);
    int w, h, rx, ry;
    w  = eff_width();
    h  = eff_height();
    rx = eff_rad(cfg_rad_x);
    ry = eff_rad(cfg_rad_y);
    if (op == OP_DRAIN) begin
      if (pend > 0) predict_result(w, h, rx, ry);
    end else begin
      line_mem[in_slot][in_col % MAX_WIDTH] = pix;
      step_pos(in_col, in_row, in_slot, w, h);
      pend++;
      if (pend > ry * w + rx) predict_result(w, h, rx, ry);
    end
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      cfg_width = 1024;
      cfg_height = 1024;
      cfg_rad_x = 1;
      cfg_rad_y = 1;
      for (int i = 0; i < 4; i++) coef_word[i] = '0;
      in_col = 0; in_row = 0; in_slot = 0;
      out_col = 0; out_row = 0; out_slot = 0;
      pend = 0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:    cfg_width = cfg_data[10:0];
          REG_HEIGHT:   cfg_height = cfg_data[15:0];
          REG_RADIUS_X: cfg_rad_x = cfg_data[1:0];
          REG_RADIUS_Y: cfg_rad_y = cfg_data[1:0];
          REG_COEF0:    coef_word[0] = cfg_data;
          REG_COEF1:    coef_word[1] = cfg_data;
          REG_COEF2:    coef_word[2] = cfg_data;
          REG_COEF3:    coef_word[3] = {56'd0, cfg_data[7:0]};
          default: ;
        endcase
      end
      if (src.valid && src.ready) take_beat(src.op, src.pixel_in);
      if (dst.valid && dst.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("unexpected result beat: pixel_out %0d", dst.pixel_out);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (dst.pixel_out !== want.pix) begin
            $error("pixel_out expected %0d got %0d", want.pix, dst.pixel_out);
            errors++;
          end
          if (dst.frame_last !== want.fin) begin
            $error("frame_last expected %0b got %0b", want.fin, dst.frame_last);
            errors++;
          end
        end
      end
    end
    outstanding = result_q.size();
  end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the image_2d_convolution testbench: clock, reset, configuration and
// pixel/drain stimulus, result back-pressure and the verdict.
// Depends on i2dc_pkg, the channel interfaces, conv_checker and the block.
module tb_top;
  import i2dc_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int                errors, outstanding, results_seen;
  int                pixels_sent, drains_sent, phases_run;
  bit                quiet, hold_req;

  i2dc_in_if  src_ch ();
  i2dc_out_if dst_ch ();

  image_2d_convolution dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_ch),
    .dst       (dst_ch)
  );

  conv_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src          (src_ch),
    .dst          (dst_ch),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    dst_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        dst_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        dst_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      dst_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_coefs();
    case ($urandom_range(0, 7))
      0: return {8{8'h7F}};
      1: return {8{8'h80}};
      2: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_beat(logic op, pixel_t pix);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      src_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    src_ch.valid    <= 1'b1;
    src_ch.op       <= op;
    src_ch.pixel_in <= pix;
    @(negedge clk);
    while (!src_ch.ready) @(negedge clk);
    @(posedge clk);
    if (op == OP_DRAIN) drains_sent++;
    else pixels_sent++;
  endtask

  // Let the last beat clear the pipeline before touching the registers.
  task automatic wait_idle();
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(logic [10:0] w, logic [15:0] h, logic [1:0] rx, logic [1:0] ry,
                              logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                              logic [7:0] c3);
    logic [CFG_W-1:0] vals [8];
    vals[REG_WIDTH]    = {53'd0, w};
    vals[REG_HEIGHT]   = {48'd0, h};
    vals[REG_RADIUS_X] = {62'd0, rx};
    vals[REG_RADIUS_Y] = {62'd0, ry};
    vals[REG_COEF0]    = c0;
    vals[REG_COEF1]    = c1;
    vals[REG_COEF2]    = c2;
    vals[REG_COEF3]    = {$urandom, $urandom_range(0, 255) << 8 | c3};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Whole frames or a pixel cap, then enough drains to flush; extra drains find nothing.
  task automatic run_frames(logic [10:0] w_raw, logic [15:0] h_raw, logic [1:0] rx_raw,
                            logic [1:0] ry_raw, int frames, int pix_cap, bit early,
                            bit extremes);
    int w, h, rx, ry, n, k;
    w  = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
    h  = (h_raw == 0) ? 1 : h_raw;
    rx = (rx_raw > 2) ? 2 : rx_raw;
    ry = (ry_raw > 2) ? 2 : ry_raw;
    n  = (pix_cap > 0) ? pix_cap : frames * w * h;
    for (int i = 0; i < n; i++) begin
      if (early && $urandom_range(0, 19) == 0) send_beat(OP_DRAIN, pixel_t'($urandom));
      if (extremes) begin
        k = i % 6;
        send_beat(OP_PIXEL, (k == 0) ? 16'sh7FFF : (k == 1) ? 16'sh8000 : (k == 2) ? 16'sh0000 :
                            (k == 3) ? 16'shFFFF : (k == 4) ? 16'sh5555 : 16'shAAAA);
      end else begin
        send_beat(OP_PIXEL, rand_pixel());
      end
    end
    repeat (ry * w + rx + $urandom_range(1, 3)) send_beat(OP_DRAIN, pixel_t'($urandom));
    src_ch.valid <= 1'b0;
    wait_idle();
    phases_run++;
  endtask

  initial begin
    int spin;
    logic [10:0] w;
    rst          = 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    src_ch.valid <= 1'b0;
    src_ch.op    <= OP_PIXEL;
    src_ch.pixel_in <= '0;
    quiet = 0;
    hold_req = 0;
    pixels_sent = 0;
    drains_sent = 0;
    phases_run = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A drain right after reset has nothing to flush.
    send_beat(OP_DRAIN, 16'sh7FFF);
    src_ch.valid <= 1'b0;
    // Fill every store row over 32 columns with extreme pixels, 5x5 at -128.
    program_regs(11'd32, 16'd5, 2'd2, 2'd2, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 8'h80);
    run_frames(11'd32, 16'd5, 2'd2, 2'd2, 1, 0, 0, 1);
    // Zero sizes and radius 3: one-pixel frames smaller than the kernel.
    program_regs(11'd0, 16'd0, 2'd3, 2'd3, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, 8'h7F);
    run_frames(11'd0, 16'd0, 2'd3, 2'd3, 4, 0, 0, 1);
    // Oversized width clamps to the full row; part of a single-row frame, center only.
    program_regs(11'd2047, 16'd1, 2'd0, 2'd0, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, 8'h7F);
    run_frames(11'd2047, 16'd1, 2'd0, 2'd0, 1, 160, 0, 0);

    // Fill the result pipeline while the sink holds off.
    program_regs(11'd16, 16'd8, 2'd2, 2'd2, rand_coefs(), rand_coefs(), rand_coefs(),
                 8'($urandom));
    hold_req = 1;
    run_frames(11'd16, 16'd8, 2'd2, 2'd2, 2, 0, 0, 0);

    while (pixels_sent < 1000) begin
      w = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(1, 12)) : 11'($urandom_range(13, 32));
      if (pixels_sent > 850) quiet = 1;
      program_regs(w, 16'($urandom_range(1, 6)), 2'($urandom), 2'($urandom), rand_coefs(),
                   rand_coefs(), rand_coefs(), 8'($urandom));
      run_frames(w, u_checker.cfg_height, u_checker.cfg_rad_x, u_checker.cfg_rad_y,
                 $urandom_range(1, 2), 0, 1, 0);
    end

    // Tallest frame, one column, left unfinished and flushed early.
    program_regs(11'd1, 16'd65535, 2'd0, 2'd2, rand_coefs(), rand_coefs(), rand_coefs(),
                 8'($urandom));
    run_frames(11'd1, 16'd65535, 2'd0, 2'd2, 1, 100, 1, 0);

    spin = 0;
    while (outstanding != 0 && spin < 100000) begin
      @(posedge clk);
      spin++;
    end
    repeat (20) @(posedge clk);
    $display("%0d phases, %0d pixel beats and %0d drain beats sent, %0d results checked",
             phases_run, pixels_sent, drains_sent, results_seen);
    $display("%0d mismatches, %0d results still pending", errors, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
